[rtl/md5bc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bc_pkg
// Shared types, constants and round helpers for the MD5 block compressor.
// ----------------------------------------------------------------------------
package md5bc_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int ROUNDS      = 64;
	localparam int POS_W       = $clog2(BLOCK_WORDS);
	localparam int RND_W       = $clog2(ROUNDS);
	localparam int SHIFT_W     = 5;
	localparam int CFG_IDX_W   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_C = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_D = 2'd3;

	// standard MD5 starting chaining words
	localparam logic [WORD_W-1:0] INIT_A_RST = 32'h6745_2301;
	localparam logic [WORD_W-1:0] INIT_B_RST = 32'hefcd_ab89;
	localparam logic [WORD_W-1:0] INIT_C_RST = 32'h98ba_dcfe;
	localparam logic [WORD_W-1:0] INIT_D_RST = 32'h1032_5476;

	// round phases (16 rounds each)
	localparam logic [1:0] PH_F = 2'd0;
	localparam logic [1:0] PH_G = 2'd1;
	localparam logic [1:0] PH_H = 2'd2;
	localparam logic [1:0] PH_I = 2'd3;

	typedef struct packed {
		logic [WORD_W-1:0] message_word;
		logic              last_of_message;
	} md5_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_a;
		logic [WORD_W-1:0] digest_b;
		logic [WORD_W-1:0] digest_c;
		logic [WORD_W-1:0] digest_d;
	} md5_out_t;

	localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// rotation amounts repeat every four rounds within a phase
	localparam logic [SHIFT_W-1:0] SHIFT_TABLE [4][4] = '{
		'{5'd7, 5'd12, 5'd17, 5'd22},
		'{5'd5, 5'd9,  5'd14, 5'd20},
		'{5'd4, 5'd11, 5'd16, 5'd23},
		'{5'd6, 5'd10, 5'd15, 5'd21}
	};

	// message word used by a round; all index math is mod 16
	function automatic logic [POS_W-1:0] msg_index(input logic [RND_W-1:0] rnd);
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] idx;
		lo = rnd[POS_W-1:0];
		case (rnd[RND_W-1:POS_W])
			PH_F:    idx = lo;
			PH_G:    idx = POS_W'(lo * 4'd5 + 4'd1);
			PH_H:    idx = POS_W'(lo * 4'd3 + 4'd5);
			PH_I:    idx = POS_W'(lo * 4'd7);
			default: idx = lo;
		endcase
		return idx;
	endfunction

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
		input logic [SHIFT_W-1:0] s);
		logic [2*WORD_W-1:0] dbl;
		dbl = {x, x} << s;
		return dbl[2*WORD_W-1:WORD_W];
	endfunction

endpackage

[rtl/md5bc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5bc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5bc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/md5_block_compress_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_block_compress_core
// Flow: a block's sixteen word beats are taken one per cycle while in FILL; the
//   digest beat is offered once the final block has passed RUN and FINISH.
// Words of the next block wait until RUN and FINISH are done; rounds come from
//   the single round unit (one MD5 round per cycle) fed by the block RAM read port.
// Reset: arst_n clears control, restores the standard initial values and
//   starts a fresh message; block RAM contents are not cleared.
// ----------------------------------------------------------------------------
module md5_block_compress_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  md5bc_pkg::md5_in_t                   in_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output md5bc_pkg::md5_out_t                  out_digest,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [md5bc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [md5bc_pkg::WORD_W-1:0]         cfg_data
);

	import md5bc_pkg::*;

	// FILL: taking word beats into the block RAM
	// RUN: 64 rounds, each RAM read issued in the cycle before its round
	// FINISH: add working words into the chain, emit digest on a final block
	typedef enum logic [1:0] {
		ST_FILL,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [WORD_W-1:0] init_q  [4];
	logic [WORD_W-1:0] chain_q [4];
	logic [WORD_W-1:0] work_q  [4];
	logic              fresh_q;
	logic              last_q;
	logic [POS_W-1:0]  pos_q;

	// round issue counter and the round stage that consumes RAM data
	logic [RND_W-1:0]  iss_q;
	logic              iss_done_q;
	logic              vld_s1;
	logic [RND_W-1:0]  rnd_s1;

	logic              out_valid_q;
	md5_out_t          out_q;

	logic              in_acc;
	logic              rd_en;
	logic [POS_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;

	logic [WORD_W-1:0] f_val;
	logic [WORD_W-1:0] rsum;
	logic [WORD_W-1:0] new_b;
	logic [WORD_W-1:0] fin [4];
	logic              out_free;

	assign in_ready  = (state_q == ST_FILL);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_digest = out_q;

	assign rd_en   = (state_q == ST_RUN) && !iss_done_q;
	assign rd_addr = msg_index(iss_q);

	md5bc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (BLOCK_WORDS)
	) u_block_ram (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (pos_q),
		.wr_data (in_word.message_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one MD5 round; work_q holds a, b, c, d
	always_comb begin
		case (rnd_s1[RND_W-1:POS_W])
			PH_F:    f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
			PH_G:    f_val = (work_q[3] & work_q[1]) | (~work_q[3] & work_q[2]);
			PH_H:    f_val = work_q[1] ^ work_q[2] ^ work_q[3];
			PH_I:    f_val = work_q[2] ^ (work_q[1] | ~work_q[3]);
			default: f_val = work_q[1];
		endcase
		rsum  = work_q[0] + f_val + K_TABLE[rnd_s1] + rd_data;
		new_b = work_q[1] + rotl(rsum, SHIFT_TABLE[rnd_s1[RND_W-1:POS_W]][rnd_s1[1:0]]);
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			fin[k] = chain_q[k] + work_q[k];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			init_q[0]   <= INIT_A_RST;
			init_q[1]   <= INIT_B_RST;
			init_q[2]   <= INIT_C_RST;
			init_q[3]   <= INIT_D_RST;
			chain_q[0]  <= INIT_A_RST;
			chain_q[1]  <= INIT_B_RST;
			chain_q[2]  <= INIT_C_RST;
			chain_q[3]  <= INIT_D_RST;
			fresh_q     <= 1'b1;
			last_q      <= 1'b0;
			pos_q       <= '0;
			iss_q       <= '0;
			iss_done_q  <= 1'b0;
			vld_s1      <= 1'b0;
			rnd_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// config writes; the user must let them arrive only while idle, as the block does not enforce this
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INITIAL_A: init_q[0] <= cfg_data;
					CFG_INITIAL_B: init_q[1] <= cfg_data;
					CFG_INITIAL_C: init_q[2] <= cfg_data;
					CFG_INITIAL_D: init_q[3] <= cfg_data;
					default: ;
				endcase
			end

			// a final block in FINISH owns out_valid_q this cycle
			if (out_valid_q && out_ready && !(state_q == ST_FINISH && last_q)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						pos_q <= POS_W'(pos_q + 1'b1);
						if (pos_q == POS_W'(BLOCK_WORDS - 1)) begin
							last_q     <= in_word.last_of_message;
							iss_q      <= '0;
							iss_done_q <= 1'b0;
							vld_s1     <= 1'b0;
							state_q    <= ST_RUN;
							// first block of a message starts from the initial values
							for (int k = 0; k < 4; k++) begin
								if (fresh_q) begin
									chain_q[k] <= init_q[k];
									work_q[k]  <= init_q[k];
								end else begin
									work_q[k]  <= chain_q[k];
								end
							end
							fresh_q <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					vld_s1 <= rd_en;
					rnd_s1 <= iss_q;
					if (rd_en) begin
						iss_q <= RND_W'(iss_q + 1'b1);
						if (iss_q == RND_W'(ROUNDS - 1)) begin
							iss_done_q <= 1'b1;
						end
					end
					if (vld_s1) begin
						work_q[0] <= work_q[3];
						work_q[1] <= new_b;
						work_q[2] <= work_q[1];
						work_q[3] <= work_q[2];
						if (rnd_s1 == RND_W'(ROUNDS - 1)) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						for (int k = 0; k < 4; k++) begin
							chain_q[k] <= fin[k];
						end
						state_q <= ST_FILL;
					end else if (out_free) begin
						// digest beat; next message reloads via fresh_q
						out_q.digest_a <= fin[0];
						out_q.digest_b <= fin[1];
						out_q.digest_c <= fin[2];
						out_q.digest_d <= fin[3];
						out_valid_q    <= 1'b1;
						fresh_q        <= 1'b1;
						state_q        <= ST_FILL;
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

endmodule
